[rtl/stsi_pkg.sv]
// Shared constants and types for the sorted table block.
package stsi_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int REQ_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2
    } t_req;

    typedef struct packed {
        logic                         ins;
        logic                         del;
        logic signed [VALUE_BITS-1:0] value;
    } t_stsi_cmd;

endpackage

[rtl/stsi_cell.sv]
// One compare-and-shift cell of the sorted table chain.
module stsi_cell
    import stsi_pkg::*;
(
    input  logic                         i_clk,
    input  t_stsi_cmd                    i_cmd,
    input  logic                         i_valid,
    input  logic                         i_left_lt,
    input  logic signed [VALUE_BITS-1:0] i_left_val,
    input  logic signed [VALUE_BITS-1:0] i_right_val,
    output logic                         o_lt,
    output logic                         o_hit,
    output logic signed [VALUE_BITS-1:0] o_val
);

    logic signed [VALUE_BITS-1:0] r_val;
    logic signed [VALUE_BITS-1:0] n_val;
    logic                         first;

    assign o_lt  = i_valid && (r_val < i_cmd.value);
    assign first = !o_lt && i_left_lt;
    assign o_hit = first && i_valid && (r_val == i_cmd.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins && !o_lt) begin
            n_val = first ? i_cmd.value : i_left_val;
        end else if (i_cmd.del && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[rtl/sorted_table_insert_delete_search.sv]
// Top level of the sorted table with insert, delete and search requests.
//
//  channel   handshake               payload
//  request   start, busy             i_req_type, i_value
//  result    o_strobe (one cycle)    o_found, o_position, o_entry_count, o_rejected,
//                                    o_smallest, o_largest
//
// A request beat is taken when start is high and busy is low.
// Every cell updates in the cycle the beat is taken, so busy is high for one cycle.
// The result appears on the cycle after that.
// A new beat may be taken in the same cycle its predecessor's result is shown.
// Reset empties the table; the receiver cannot stall results.
module sorted_table_insert_delete_search
    import stsi_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [REQ_W-1:0]             i_req_type,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_strobe,
    output logic                         o_found,
    output logic [CNT_W-1:0]             o_position,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic                         o_rejected,
    output logic signed [VALUE_BITS-1:0] o_smallest,
    output logic signed [VALUE_BITS-1:0] o_largest
);

    logic                         r_busy;
    logic                         r_strobe;
    logic [CNT_W-1:0]             r_count;
    logic                         r_found;
    logic [CNT_W-1:0]             r_pos;
    logic                         r_rej;
    logic                         r_o_found;
    logic [CNT_W-1:0]             r_o_pos;
    logic [CNT_W-1:0]             r_o_count;
    logic                         r_o_rej;
    logic signed [VALUE_BITS-1:0] r_o_small;
    logic signed [VALUE_BITS-1:0] r_o_large;

    logic                         accept;
    logic                         full;
    logic                         found;
    logic [CNT_W-1:0]             pos;
    logic signed [VALUE_BITS-1:0] largest;
    t_stsi_cmd                    cmd;

    logic [DEPTH-1:0]             cell_valid;
    logic [DEPTH-1:0]             cell_lt;
    logic [DEPTH-1:0]             cell_hit;
    logic [DEPTH-1:0]             cell_last;
    logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
    logic [CNT_W-1:0]             pos_term [DEPTH];

    assign accept    = start && !r_busy;
    assign full      = (r_count == CNT_W'(DEPTH));
    assign cmd.value = i_value;
    assign cmd.ins   = accept && (i_req_type == REQ_INSERT) && !full;
    assign cmd.del   = accept && (i_req_type == REQ_DELETE) && found;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign cell_valid[g] = (r_count > CNT_W'(g));
        assign cell_last[g]  = (r_count == CNT_W'(g + 1));
        assign pos_term[g]   = cell_hit[g] ? CNT_W'(g + 1) : '0;

        stsi_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_valid     (cell_valid[g]),
            .i_left_lt   ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
            .i_left_val  (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right_val (cell_val[(g == DEPTH - 1) ? DEPTH - 1 : g + 1]),
            .o_lt        (cell_lt[g]),
            .o_hit       (cell_hit[g]),
            .o_val       (cell_val[g])
        );
    end

    always_comb begin
        pos     = '0;
        largest = '0;
        for (int k = 0; k < DEPTH; k++) begin
            pos     = pos | pos_term[k];
            largest = largest | (cell_last[k] ? cell_val[k] : '0);
        end
    end

    assign found = |cell_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
            if (cmd.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (cmd.del) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found <= found;
            r_pos   <= pos;
            r_rej   <= (i_req_type == REQ_INSERT) && full;
        end
        if (r_busy) begin
            r_o_found <= r_found;
            r_o_pos   <= r_pos;
            r_o_count <= r_count;
            r_o_rej   <= r_rej;
            r_o_small <= (r_count != '0) ? cell_val[0] : '0;
            r_o_large <= largest;
        end
    end

    assign busy          = r_busy;
    assign o_strobe      = r_strobe;
    assign o_found       = r_o_found;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_count;
    assign o_rejected    = r_o_rej;
    assign o_smallest    = r_o_small;
    assign o_largest     = r_o_large;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_strobe)
        else $error("Result strobe did not follow the update cycle.");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_hit))
        else $error("More than one cell claims the first match.");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_o_rej) |-> (r_o_count == CNT_W'(DEPTH)))
        else $error("Insert rejected while the table was not full.");

endmodule

[tb/sv/sorted_table_insert_delete_search_test.sv]
// Self-checking testbench for the sorted table: random fill, drain and mixed requests.
`timescale 1ns / 1ps

module sorted_table_insert_delete_search_test;
    import stsi_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = ~VAL_MIN;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 560;

    typedef struct {
        logic                         found;
        logic [CNT_W-1:0]             position;
        logic [CNT_W-1:0]             entry_count;
        logic                         rejected;
        logic signed [VALUE_BITS-1:0] smallest;
        logic signed [VALUE_BITS-1:0] largest;
    } t_answer;

    class table_mirror;
        logic signed [VALUE_BITS-1:0] slots[DEPTH];
        int fill;
        t_answer pending_answers[$];
        int mismatches;
        int hits;
        int refusals;
        int peak_fill;

        function new();
            fill = 0;
            mismatches = 0;
            hits = 0;
            refusals = 0;
            peak_fill = 0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic signed [VALUE_BITS-1:0] val);
            t_answer a;
            int lower;
            int k;
            lower = 0;
            while (lower < fill && slots[lower] < val)
                lower++;
            a.found = (lower < fill) && (slots[lower] == val);
            a.rejected = 1'b0;
            if (req == REQ_INSERT) begin
                if (fill >= DEPTH) begin
                    a.rejected = 1'b1;
                    refusals++;
                end else begin
                    for (k = fill; k > lower; k--)
                        slots[k] = slots[k-1];
                    slots[lower] = val;
                    fill++;
                end
            end else if (req == REQ_DELETE && a.found) begin
                for (k = lower; k + 1 < fill; k++)
                    slots[k] = slots[k+1];
                fill--;
            end
            if (a.found)
                hits++;
            if (fill > peak_fill)
                peak_fill = fill;
            a.position = a.found ? CNT_W'(lower + 1) : '0;
            a.entry_count = CNT_W'(fill);
            a.smallest = (fill > 0) ? slots[0] : '0;
            a.largest = (fill > 0) ? slots[fill-1] : '0;
            pending_answers.push_back(a);
        endfunction

        function void compare_field(string tag, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
                mismatches++;
            end
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $display("%0t: result beat with no request outstanding, expected none, actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("position", want.position, got.position);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("rejected", want.rejected, got.rejected);
            compare_field("smallest", want.smallest, got.smallest);
            compare_field("largest", want.largest, got.largest);
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [REQ_W-1:0]             i_req_type = REQ_SEARCH;
    logic signed [VALUE_BITS-1:0] i_value = '0;
    logic                         o_strobe;
    logic                         o_found;
    logic [CNT_W-1:0]             o_position;
    logic [CNT_W-1:0]             o_entry_count;
    logic                         o_rejected;
    logic signed [VALUE_BITS-1:0] o_smallest;
    logic signed [VALUE_BITS-1:0] o_largest;

    table_mirror book;
    int cycles = 0;
    int sent = 0;
    int rounds = 0;
    bit quiet = 1'b0;

    sorted_table_insert_delete_search i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_entry_count(o_entry_count),
        .o_rejected   (o_rejected),
        .o_smallest   (o_smallest),
        .o_largest    (o_largest)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        if (i_rst_n && o_strobe) begin
            got.found = o_found;
            got.position = o_position;
            got.entry_count = o_entry_count;
            got.rejected = o_rejected;
            got.smallest = o_smallest;
            got.largest = o_largest;
            book.check_answer(got);
        end
    end

    // A beat is taken at the first edge where start is high and busy is low.
    task automatic send(logic [REQ_W-1:0] req, logic signed [VALUE_BITS-1:0] val);
        i_req_type <= req;
        i_value <= val;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        book.note_request(req, val);
        sent++;
        if (!quiet && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [REQ_W-1:0] pick_request(int insert_pct, int delete_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return REQ_INSERT;
        else if (r < insert_pct + delete_pct)
            return REQ_DELETE;
        else if (r < 96)
            return REQ_SEARCH;
        return REQ_SPARE;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value(int hit_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < hit_pct && book.fill > 0)
            return book.slots[$urandom_range(0, book.fill - 1)];
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return VALUE_BITS'(int'($urandom_range(0, 16)) - 8);
        if (sel < 65) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return -1;
                default: return '0;
            endcase
        end
        return VALUE_BITS'($urandom);
    endfunction

    task automatic fill_table();
        int guard;
        guard = 0;
        while (book.fill < DEPTH && guard < 400 && sent < RANDOM_ITEMS) begin
            send(pick_request(70, 12), pick_value(20));
            guard++;
        end
        repeat (8) send(pick_request(80, 5), pick_value(30));
    endtask

    task automatic drain_table();
        int guard;
        guard = 0;
        while (book.fill > 0 && guard < 400 && sent < RANDOM_ITEMS) begin
            send(pick_request(10, 75), pick_value(75));
            guard++;
        end
        repeat (4) send(pick_request(10, 60), pick_value(50));
    endtask

    initial begin
        book = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_SEARCH, VAL_MIN);
        send(REQ_DELETE, 0);
        send(REQ_SPARE, 0);
        send(REQ_INSERT, 0);
        send(REQ_INSERT, VAL_MAX);
        send(REQ_INSERT, VAL_MIN);
        send(REQ_INSERT, 0);
        send(REQ_INSERT, -1);
        send(REQ_INSERT, 1);
        send(REQ_SEARCH, 0);
        send(REQ_SEARCH, 5);
        send(REQ_SPARE, 1);
        send(REQ_DELETE, 0);
        send(REQ_DELETE, 0);
        send(REQ_DELETE, 0);
        send(REQ_INSERT, VAL_MAX);
        send(REQ_DELETE, VAL_MAX);
        send(REQ_SEARCH, VAL_MIN);
        send(REQ_SEARCH, VAL_MAX);
        send(REQ_INSERT, 32'h5555_5555);
        send(REQ_INSERT, 32'hAAAA_AAAA);
        send(REQ_DELETE, VAL_MIN);
        send(REQ_SEARCH, -1);

        while (sent < RANDOM_ITEMS) begin
            quiet = (rounds == 1);
            fill_table();
            drain_table();
            rounds++;
        end
        quiet = 1'b0;
        repeat (40) send(pick_request(40, 30), pick_value(40));
        start <= 1'b0;

        while (book.pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d requests over %0d fill and drain rounds; %0d found their value.",
                 sent, rounds, book.hits);
        $display("Table peaked at %0d of %0d entries, %0d inserts refused, %0d mismatches.",
                 book.peak_fill, DEPTH, book.refusals, book.mismatches);
        if (book.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sorted_table_insert_delete_search.f]
rtl/stsi_pkg.sv
rtl/stsi_cell.sv
rtl/sorted_table_insert_delete_search.sv
tb/sv/sorted_table_insert_delete_search_test.sv
